>>> hdl/xwbm_pkg.sv
package xwbm_pkg;

    localparam int unsigned DATA_W = 64;
    localparam int unsigned IDX_W  = 7;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_SEARCH = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    typedef logic [DATA_W-1:0] word_t;
    typedef logic [IDX_W-1:0]  idx_t;

    typedef struct packed {
        logic clear;
        logic step;
        idx_t idx;
    } acc_ctrl_t;

    typedef struct packed {
        word_t best_data;
        word_t read_data;
        logic  found;
        idx_t  match_index;
        idx_t  best_index;
        idx_t  best_score;
    } acc_res_t;

    function automatic idx_t zero_score(word_t x);
        idx_t lo;
        idx_t hi;
        lo = '0;
        hi = '0;
        for (int i = DATA_W - 1; i >= 0; i--)
        begin
            if (x[i])
            begin
                lo = IDX_W'(i);
            end
        end
        for (int i = 0; i < DATA_W; i++)
        begin
            if (x[i])
            begin
                hi = IDX_W'(i);
            end
        end
        if (x == '0)
        begin
            return IDX_W'(DATA_W);
        end
        return IDX_W'(DATA_W - 1) - hi + lo;
    endfunction

endpackage

>>> hdl/xwbm_if.sv
interface xwbm_req_if;
    import xwbm_pkg::*;

    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    word_t      value;
    idx_t       offset;

    modport source (output valid, output opcode, output value, output offset, input ready);
    modport sink   (input valid, input opcode, input value, input offset, output ready);
endinterface

interface xwbm_rsp_if;
    import xwbm_pkg::*;

    logic  valid;
    logic  ready;
    word_t data_out;
    logic  found;
    idx_t  match_index;
    idx_t  best_index;
    idx_t  best_score;

    modport source (output valid, output data_out, output found, output match_index,
                    output best_index, output best_score, input ready);
    modport sink   (input valid, input data_out, input found, input match_index,
                    input best_index, input best_score, output ready);
endinterface

>>> hdl/xwbm_cell.sv
module xwbm_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           shift,
    input  xwbm_pkg::word_t d,
    output xwbm_pkg::word_t q
);
    import xwbm_pkg::*;

    word_t entry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else if (shift)
        begin
            entry_reg <= d;
        end
    end

    assign q = entry_reg;
endmodule

>>> hdl/xwbm_acc.sv
module xwbm_acc #(
    parameter int unsigned WINDOW_DEPTH = 127
) (
    input  logic                clk,
    input  logic                rst_n,
    input  xwbm_pkg::acc_ctrl_t ctrl,
    input  xwbm_pkg::word_t     key,
    input  xwbm_pkg::idx_t      offset,
    input  xwbm_pkg::word_t     entry,
    output xwbm_pkg::acc_res_t  res
);
    import xwbm_pkg::*;

    localparam idx_t NO_MATCH = IDX_W'(WINDOW_DEPTH);

    word_t best_d_reg;
    word_t rd_reg;
    idx_t  best_s_reg;
    idx_t  best_i_reg;
    idx_t  match_reg;
    idx_t  score;

    assign score = zero_score(key ^ entry);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_s_reg <= '0;
            best_i_reg <= '0;
            match_reg  <= NO_MATCH;
            best_d_reg <= '0;
            rd_reg     <= '0;
        end
        else if (ctrl.clear)
        begin
            best_s_reg <= '0;
            best_i_reg <= '0;
            match_reg  <= NO_MATCH;
            best_d_reg <= '0;
            rd_reg     <= '0;
        end
        else if (ctrl.step)
        begin
            // entries arrive oldest first: keep the later one on ties
            if (score >= best_s_reg)
            begin
                best_s_reg <= score;
                best_i_reg <= ctrl.idx;
                best_d_reg <= entry;
            end
            if (entry == key)
            begin
                match_reg <= ctrl.idx;
            end
            if (ctrl.idx == offset)
            begin
                rd_reg <= entry;
            end
        end
    end

    assign res.best_data   = best_d_reg;
    assign res.read_data   = rd_reg;
    assign res.found       = (match_reg != NO_MATCH);
    assign res.match_index = match_reg;
    assign res.best_index  = best_i_reg;
    assign res.best_score  = best_s_reg;
endmodule

>>> hdl/xor_window_best_match_top.sv
// Sliding window of the WINDOW_DEPTH most recent 64-bit values, newest at
// index 0, all zero after reset. The window lives in a chain of cells, one
// entry per cell. Insert (opcode 0) shifts the chain and gives no item.
// Search (opcode 1) and read (opcode 2) are accepted, then rotate the chain
// once around past a single scoring unit at the chain end, then load the
// result register, after which the window is back in place. No new request
// is taken until that load. The load waits while the receiver still holds
// the previous result. Search reports the first matching index (WINDOW_DEPTH
// if absent) and the lowest-index entry with most leading plus trailing
// zeros in its XOR with the key. Read of an offset at or beyond WINDOW_DEPTH
// returns zero. Opcode 3 is accepted and dropped.
module xor_window_best_match_top #(
    parameter int unsigned WINDOW_DEPTH = 127
) (
    input logic        clk,
    input logic        rst_n,
    xwbm_req_if.sink   req,
    xwbm_rsp_if.source rsp
);
    import xwbm_pkg::*;

    localparam int unsigned CNT_W    = $clog2(WINDOW_DEPTH);
    localparam idx_t        LAST_IDX = IDX_W'(WINDOW_DEPTH - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [1:0]       op_reg;
    word_t            key_reg;
    idx_t             off_reg;

    logic     out_valid_reg;
    word_t    data_reg;
    logic     found_reg;
    idx_t     match_reg;
    idx_t     best_i_reg;
    idx_t     best_s_reg;

    word_t     chain [WINDOW_DEPTH];
    word_t     head_d;
    logic      shift;
    logic      accept;
    acc_ctrl_t ctrl;
    acc_res_t  res;

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign shift     = (accept && req.opcode == OP_INSERT) || (state_reg == S_SCAN);
    assign head_d    = (state_reg == S_SCAN) ? chain[WINDOW_DEPTH-1] : req.value;

    xwbm_cell u_cell0 (
        .clk   (clk),
        .rst_n (rst_n),
        .shift (shift),
        .d     (head_d),
        .q     (chain[0])
    );

    for (genvar i = 1; i < WINDOW_DEPTH; i++)
    begin : g_cell
        xwbm_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .shift (shift),
            .d     (chain[i-1]),
            .q     (chain[i])
        );
    end

    assign ctrl.clear = accept && (req.opcode == OP_SEARCH || req.opcode == OP_READ);
    assign ctrl.step  = (state_reg == S_SCAN);
    assign ctrl.idx   = LAST_IDX - IDX_W'(cnt_reg);

    xwbm_acc #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_acc (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .key    (key_reg),
        .offset (off_reg),
        .entry  (chain[WINDOW_DEPTH-1]),
        .res    (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            op_reg        <= OP_INSERT;
            key_reg       <= '0;
            off_reg       <= '0;
            out_valid_reg <= 1'b0;
            data_reg      <= '0;
            found_reg     <= 1'b0;
            match_reg     <= '0;
            best_i_reg    <= '0;
            best_s_reg    <= '0;
        end
        else
        begin
            if (out_valid_reg && rsp.ready && state_reg != S_FINISH)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (ctrl.clear)
                    begin
                        state_reg <= S_SCAN;
                        cnt_reg   <= '0;
                        op_reg    <= req.opcode;
                        key_reg   <= req.value;
                        off_reg   <= req.offset;
                    end
                end
                S_SCAN:
                begin
                    if (cnt_reg == CNT_W'(WINDOW_DEPTH - 1))
                    begin
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_FINISH:
                begin
                    if (!out_valid_reg || rsp.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                        if (op_reg == OP_SEARCH)
                        begin
                            data_reg   <= res.best_data;
                            found_reg  <= res.found;
                            match_reg  <= res.match_index;
                            best_i_reg <= res.best_index;
                            best_s_reg <= res.best_score;
                        end
                        else
                        begin
                            data_reg   <= res.read_data;
                            found_reg  <= 1'b0;
                            match_reg  <= '0;
                            best_i_reg <= '0;
                            best_s_reg <= '0;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.data_out    = data_reg;
    assign rsp.found       = found_reg;
    assign rsp.match_index = match_reg;
    assign rsp.best_index  = best_i_reg;
    assign rsp.best_score  = best_s_reg;
endmodule

>>> test/tb_xor_window_best_match_top.sv
module tb_xor_window_best_match_top;
    import xwbm_pkg::*;

    localparam int unsigned WINDOW_DEPTH = 127;
    localparam int unsigned CYCLE_LIMIT  = 4000000;
    localparam int unsigned RANDOM_ITEMS = 1630;
    localparam int unsigned PRINT_LIMIT  = 40;
    localparam logic [1:0]  OP_UNUSED    = 2'd3;

    typedef struct {
        word_t data;
        logic  found;
        idx_t  match_index;
        idx_t  best_index;
        idx_t  best_score;
    } outcome_t;

    class window_tracker;
        word_t       entries [WINDOW_DEPTH];
        outcome_t    pending_outcomes [$];
        int unsigned mismatches;

        function new();
            foreach (entries[i])
            begin
                entries[i] = '0;
            end
            mismatches = 0;
        endfunction

        function int unsigned xor_zero_score(word_t x);
            int unsigned lead;
            int unsigned trail;
            if (x == '0)
            begin
                return 64;
            end
            lead = 0;
            while (x[63 - lead] == 1'b0)
            begin
                lead++;
            end
            trail = 0;
            while (x[trail] == 1'b0)
            begin
                trail++;
            end
            return lead + trail;
        endfunction

        function void note_request(logic [1:0] op, word_t v, idx_t off);
            outcome_t    o;
            int unsigned s;
            int unsigned match;
            int unsigned best_i;
            int unsigned best_s;
            case (op)
                OP_INSERT:
                begin
                    for (int i = WINDOW_DEPTH - 1; i > 0; i--)
                    begin
                        entries[i] = entries[i - 1];
                    end
                    entries[0] = v;
                end
                OP_SEARCH:
                begin
                    match  = WINDOW_DEPTH;
                    best_i = 0;
                    best_s = 0;
                    for (int i = 0; i < WINDOW_DEPTH; i++)
                    begin
                        s = xor_zero_score(v ^ entries[i]);
                        if (entries[i] == v && match == WINDOW_DEPTH)
                        begin
                            match = i;
                        end
                        if (i == 0 || s > best_s)
                        begin
                            best_s = s;
                            best_i = i;
                        end
                    end
                    o.data        = entries[best_i];
                    o.found       = (match < WINDOW_DEPTH);
                    o.match_index = idx_t'(match);
                    o.best_index  = idx_t'(best_i);
                    o.best_score  = idx_t'(best_s);
                    pending_outcomes.push_back(o);
                end
                OP_READ:
                begin
                    o.data        = (off < WINDOW_DEPTH) ? entries[off] : '0;
                    o.found       = 1'b0;
                    o.match_index = '0;
                    o.best_index  = '0;
                    o.best_score  = '0;
                    pending_outcomes.push_back(o);
                end
                default:
                begin
                end
            endcase
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= PRINT_LIMIT)
            begin
                $display("[%0t] mismatch: %s", $realtime, msg);
            end
        endtask

        task check_outcome(outcome_t got);
            outcome_t exp;
            if (pending_outcomes.size() == 0)
            begin
                report($sformatf("unexpected item data_out=%h", got.data));
                return;
            end
            exp = pending_outcomes.pop_front();
            if (got.data !== exp.data)
            begin
                report($sformatf("data_out %h, want %h", got.data, exp.data));
            end
            if (got.found !== exp.found)
            begin
                report($sformatf("found %b, want %b", got.found, exp.found));
            end
            if (got.match_index !== exp.match_index)
            begin
                report($sformatf("match_index %0d, want %0d",
                                 got.match_index, exp.match_index));
            end
            if (got.best_index !== exp.best_index)
            begin
                report($sformatf("best_index %0d, want %0d",
                                 got.best_index, exp.best_index));
            end
            if (got.best_score !== exp.best_score)
            begin
                report($sformatf("best_score %0d, want %0d",
                                 got.best_score, exp.best_score));
            end
        endtask
    endclass

    logic clk;
    logic rst_n;

    xwbm_req_if req_ch();
    xwbm_rsp_if rsp_ch();

    xor_window_best_match_top #(
        .WINDOW_DEPTH(WINDOW_DEPTH)
    ) uut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .rsp  (rsp_ch)
    );

    window_tracker tracker = new();
    bit            sender_calm = 1'b0;
    word_t         recent_vals [$];

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(12, 90);
    endfunction

    function automatic word_t pick_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return word_t'(1) << $urandom_range(0, 63);
            3: return ~(word_t'(1) << $urandom_range(0, 63));
            4: return word_t'($urandom_range(0, 255));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic word_t flip_bits(word_t v);
        word_t w;
        w = v;
        repeat ($urandom_range(1, 3))
        begin
            w = w ^ (word_t'(1) << $urandom_range(0, 63));
        end
        return w;
    endfunction

    task automatic send_item(logic [1:0] op, word_t v, idx_t off);
        int unsigned gap;
        gap = sender_calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid  <= 1'b1;
        req_ch.opcode <= op;
        req_ch.value  <= v;
        req_ch.offset <= off;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        tracker.note_request(op, v, off);
        if (op == OP_INSERT)
        begin
            recent_vals.push_back(v);
            if (recent_vals.size() > 48)
            begin
                recent_vals.delete(0);
            end
        end
    endtask

    task automatic run_directed();
        send_item(OP_SEARCH, '0, 7'd0);
        send_item(OP_SEARCH, '1, 7'd127);
        send_item(OP_READ, '1, 7'd0);
        send_item(OP_READ, '0, 7'd126);
        send_item(OP_READ, '1, 7'd127);
        send_item(OP_UNUSED, '1, 7'd0);
        send_item(OP_READ, '0, 7'd0);
        send_item(OP_INSERT, '1, 7'd0);
        send_item(OP_INSERT, 64'h8000_0000_0000_0001, 7'd127);
        send_item(OP_INSERT, 64'h0000_0000_0000_0001, 7'd0);
        send_item(OP_INSERT, 64'h8000_0000_0000_0000, 7'd0);
        send_item(OP_SEARCH, '1, 7'd0);
        send_item(OP_SEARCH, '0, 7'd0);
        send_item(OP_SEARCH, 64'h0000_0001_0000_0000, 7'd0);
        send_item(OP_SEARCH, 64'h8000_0000_0000_0001, 7'd0);
        send_item(OP_READ, '0, 7'd3);
        send_item(OP_READ, '0, 7'd126);
        send_item(OP_READ, '0, 7'd127);
        send_item(OP_INSERT, 64'h0000_0000_0000_0001, 7'd0);
        send_item(OP_SEARCH, 64'h0000_0000_0000_0001, 7'd0);
        send_item(OP_UNUSED, '0, 7'd127);
        send_item(OP_SEARCH, 64'h5555_AAAA_5555_AAAA, 7'd64);
    endtask

    task automatic run_random();
        int unsigned r;
        logic [1:0]  op;
        word_t       v;
        idx_t        off;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 128 == 0)
            begin
                sender_calm = ($urandom_range(0, 3) == 0);
            end
            r = $urandom_range(0, 99);
            if (r < 45)
            begin
                op = OP_INSERT;
            end
            else if (r < 75)
            begin
                op = OP_SEARCH;
            end
            else if (r < 95)
            begin
                op = OP_READ;
            end
            else
            begin
                op = OP_UNUSED;
            end
            off = ($urandom_range(0, 9) == 0) ? idx_t'($urandom_range(120, 127))
                                              : idx_t'($urandom_range(0, 127));
            v = pick_word();
            if (op == OP_SEARCH && recent_vals.size() > 0)
            begin
                r = $urandom_range(0, 99);
                if (r < 40)
                begin
                    v = recent_vals[$urandom_range(0, recent_vals.size() - 1)];
                end
                else if (r < 70)
                begin
                    v = flip_bits(recent_vals[$urandom_range(0, recent_vals.size() - 1)]);
                end
            end
            send_item(op, v, off);
        end
        req_ch.valid <= 1'b0;
    endtask

    initial
    begin
        int unsigned stall_left;
        int unsigned mode_left;
        int unsigned results;
        bit          pressed;
        bit          calm;
        outcome_t    got;
        stall_left   = 0;
        mode_left    = 0;
        results      = 0;
        pressed      = 1'b0;
        calm         = 1'b0;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got.data        = rsp_ch.data_out;
                got.found       = rsp_ch.found;
                got.match_index = rsp_ch.match_index;
                got.best_index  = rsp_ch.best_index;
                got.best_score  = rsp_ch.best_score;
                tracker.check_outcome(got);
                results++;
            end
            if (mode_left == 0)
            begin
                calm      = ($urandom_range(0, 3) == 0);
                mode_left = $urandom_range(200, 2000);
            end
            else
            begin
                mode_left--;
            end
            // hold off long enough for the block to back up and stall its input
            if (!pressed && results == 120)
            begin
                pressed    = 1'b1;
                stall_left = 3000;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if (!calm && $urandom_range(0, 3) == 0)
                begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    initial
    begin
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        req_ch.valid  = 1'b0;
        req_ch.opcode = OP_INSERT;
        req_ch.value  = '0;
        req_ch.offset = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random();
        while (tracker.pending_outcomes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (2 * WINDOW_DEPTH + 8) @(posedge clk);
        if (tracker.pending_outcomes.size() == 0 && tracker.mismatches == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
